/* src/motor_feedback_frame_decoder_core_assert.svh */
// Assertion macros for the motor feedback frame decoder.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef MOTOR_FEEDBACK_FRAME_DECODER_CORE_ASSERT_SVH
`define MOTOR_FEEDBACK_FRAME_DECODER_CORE_ASSERT_SVH

// Consequent checked at the same clock edge as the antecedent.
`define MFFD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked at the clock edge after the antecedent.
`define MFFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/mffd_pkg.sv */
// Shared constants for the motor feedback frame decoder.
// No dependencies.
package mffd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_EXPECTED_ID = 3'd0;
    localparam logic [2:0] CFG_SPEED_W     = 3'd1;
    localparam logic [2:0] CFG_CURRENT_W   = 3'd2;
    localparam logic [2:0] CFG_DEG_PER_CNT = 3'd3;
    localparam logic [2:0] CFG_RPM_SCALE   = 3'd4;

    // Register reset values.
    localparam logic [10:0] RST_EXPECTED_ID = 11'd513;
    localparam logic [16:0] RST_SPEED_W     = 17'd55706;
    localparam logic [16:0] RST_CURRENT_W   = 17'd58982;
    localparam logic [23:0] RST_DEG_PER_CNT = 24'd737280;
    localparam logic [15:0] RST_RPM_SCALE   = 16'd1536;

    // Fixed-point constants.
    localparam logic [16:0]        ONE_Q16       = 17'd65536;
    localparam logic signed [16:0] TURN_HALF     = 17'sd4096;
    localparam logic signed [25:0] FULL_TURN_Q16 = 26'sd23592960;
    localparam logic [27:0]        ANGLE_MAX     = 28'hFFFFFFF;

    // Stream widths.
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 11;
    localparam int OUT_DATA_W = 216;
    localparam int CFG_DATA_W = 24;

endpackage

/* src/motor_feedback_frame_decoder_core.sv */
// Motor feedback frame decoder: a matching frame steps through the five multiply states,
// S_ADD_TOTAL and S_DONE to the output register, a rejected frame straight to S_DONE.
// S_DONE waits while the output register is full and not taken; no new frame is taken
// until S_IDLE. One shared 34x26 multiplier forms five products in sequence per frame.
// Reset (synchronous, active low) clears the filters, turn and frame counts and
// restores the configuration registers to their defaults.
`include "motor_feedback_frame_decoder_core_assert.svh"

module motor_feedback_frame_decoder_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Slave side. tdata: encoder_count[15:0], speed_rpm[31:16],
    // raw_current[47:32], temperature[55:48].
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [mffd_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    // tuser: frame_id[10:0].
    input  logic [mffd_pkg::IN_USER_W-1:0]        i_s_axis_tuser,
    // Master side. tdata: single_turn_angle[27:0], filtered_speed[59:28],
    // filtered_current[75:60], temperature_out[83:76], turn_count[115:84],
    // unwrapped_angle[179:116], frame_count[211:180], zero fill[215:212].
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [mffd_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    // tuser: accepted[0].
    output logic [0:0]                            o_m_axis_tuser,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [2:0]                            i_cfg_addr,
    input  logic [mffd_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import mffd_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_MUL_SPEED = 3'd1;
    localparam logic [2:0] S_MUL_ANGLE = 3'd2;
    localparam logic [2:0] S_MUL_SFILT = 3'd3;
    localparam logic [2:0] S_MUL_CFILT = 3'd4;
    localparam logic [2:0] S_MUL_TOTAL = 3'd5;
    localparam logic [2:0] S_ADD_TOTAL = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    // Configuration.
    logic [10:0] r_cfg_id;
    logic [16:0] r_cfg_speed_w;
    logic [16:0] r_cfg_current_w;
    logic [23:0] r_cfg_dpc;
    logic [15:0] r_cfg_rpm_scale;

    // Block state.
    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [15:0]        r_last_enc;
    logic signed [31:0] r_speed;
    logic signed [15:0] r_current;
    logic signed [31:0] r_turns;
    logic [31:0]        r_frames;
    logic [7:0]         r_temp;

    // Working registers.
    logic signed [15:0] r_rpm;
    logic signed [16:0] r_cdiff;
    logic signed [32:0] r_sdiff;
    logic signed [59:0] r_prod;
    logic [27:0]        r_angle;
    logic [63:0]        r_total;
    logic               r_res_acc;

    // Output register.
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                  r_m_user;

    // Input fields.
    logic [15:0]        w_enc;
    logic signed [15:0] w_rpm;
    logic signed [15:0] w_cur;
    logic [7:0]         w_temp;
    logic               w_in_acc;
    logic               w_id_match;
    logic signed [16:0] w_enc_delta;
    logic               w_out_free;

    // Shared multiplier.
    logic signed [33:0] w_mul_a;
    logic signed [25:0] w_mul_b;
    logic signed [59:0] w_prod;

    logic [16:0]        w_speed_w;
    logic [16:0]        w_current_w;
    logic [31:0]        w_angle_raw;
    logic signed [44:0] w_spd_sum;
    logic signed [31:0] w_spd_new;
    logic signed [39:0] w_cur_acc;
    logic signed [24:0] w_cur_q;
    logic signed [15:0] w_cur_new;
    logic [OUT_DATA_W-1:0] w_res_data;

    assign w_enc  = i_s_axis_tdata[15:0];
    assign w_rpm  = $signed(i_s_axis_tdata[31:16]);
    assign w_cur  = $signed(i_s_axis_tdata[47:32]);
    assign w_temp = i_s_axis_tdata[55:48];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_id_match      = (i_s_axis_tuser[10:0] == r_cfg_id);
    assign w_enc_delta     = $signed({1'b0, w_enc}) - $signed({1'b0, r_last_enc});
    assign w_out_free      = !r_m_valid || i_m_axis_tready;

    // A weight above one acts as one.
    assign w_speed_w   = (r_cfg_speed_w > ONE_Q16) ? ONE_Q16 : r_cfg_speed_w;
    assign w_current_w = (r_cfg_current_w > ONE_Q16) ? ONE_Q16 : r_cfg_current_w;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_MUL_SPEED: begin
                w_mul_a = {{18{r_rpm[15]}}, r_rpm};
                w_mul_b = {10'd0, r_cfg_rpm_scale};
            end
            S_MUL_ANGLE: begin
                w_mul_a = {10'd0, r_cfg_dpc};
                w_mul_b = {10'd0, r_last_enc};
            end
            S_MUL_SFILT: begin
                w_mul_a = {r_sdiff[32], r_sdiff};
                w_mul_b = {9'd0, w_speed_w};
            end
            S_MUL_CFILT: begin
                w_mul_a = {{17{r_cdiff[16]}}, r_cdiff};
                w_mul_b = {9'd0, w_current_w};
            end
            S_MUL_TOTAL: begin
                w_mul_a = {{2{r_turns[31]}}, r_turns};
                w_mul_b = FULL_TURN_Q16;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Angle: drop 8 fraction bits and saturate to 28 bits.
    assign w_angle_raw = r_prod[39:8];

    // Speed filter: old + floor(w * (sample - old) / 2^16), saturated.
    assign w_spd_sum = {{13{r_speed[31]}}, r_speed} + {r_prod[59], r_prod[59:16]};
    always_comb begin
        if (w_spd_sum > 45'sh0_7FFF_FFFF) begin
            w_spd_new = 32'sh7FFF_FFFF;
        end else if (w_spd_sum < -45'sh0_8000_0000) begin
            w_spd_new = -32'sh8000_0000;
        end else begin
            w_spd_new = w_spd_sum[31:0];
        end
    end

    // Current filter: quotient by 2^16 truncated toward zero, saturated.
    assign w_cur_acc = {{8{r_current[15]}}, r_current, 16'd0} + r_prod[39:0];
    assign w_cur_q   = {w_cur_acc[39], w_cur_acc[39:16]}
                     + {24'd0, (w_cur_acc[39] && (w_cur_acc[15:0] != 16'd0))};
    always_comb begin
        if (w_cur_q > 25'sd32767) begin
            w_cur_new = 16'sh7FFF;
        end else if (w_cur_q < -25'sd32768) begin
            w_cur_new = -16'sh8000;
        end else begin
            w_cur_new = w_cur_q[15:0];
        end
    end

    always_comb begin
        if (r_res_acc) begin
            w_res_data = {4'd0, r_frames, r_total, r_turns, r_temp, r_current,
                          r_speed, r_angle};
        end else begin
            w_res_data = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_id_match ? S_MUL_SPEED : S_DONE;
                end
            end
            S_MUL_SPEED: n_state = S_MUL_ANGLE;
            S_MUL_ANGLE: n_state = S_MUL_SFILT;
            S_MUL_SFILT: n_state = S_MUL_CFILT;
            S_MUL_CFILT: n_state = S_MUL_TOTAL;
            S_MUL_TOTAL: n_state = S_ADD_TOTAL;
            S_ADD_TOTAL: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cfg_id        <= RST_EXPECTED_ID;
            r_cfg_speed_w   <= RST_SPEED_W;
            r_cfg_current_w <= RST_CURRENT_W;
            r_cfg_dpc       <= RST_DEG_PER_CNT;
            r_cfg_rpm_scale <= RST_RPM_SCALE;
            r_last_enc      <= '0;
            r_speed         <= '0;
            r_current       <= '0;
            r_turns         <= '0;
            r_frames        <= '0;
            r_temp          <= '0;
            r_res_acc       <= 1'b0;
            r_m_valid       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_EXPECTED_ID: r_cfg_id        <= i_cfg_wdata[10:0];
                    CFG_SPEED_W:     r_cfg_speed_w   <= i_cfg_wdata[16:0];
                    CFG_CURRENT_W:   r_cfg_current_w <= i_cfg_wdata[16:0];
                    CFG_DEG_PER_CNT: r_cfg_dpc       <= i_cfg_wdata[23:0];
                    CFG_RPM_SCALE:   r_cfg_rpm_scale <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                r_res_acc <= w_id_match;
                if (w_id_match) begin
                    r_frames   <= r_frames + 32'd1;
                    r_temp     <= w_temp;
                    r_last_enc <= w_enc;
                    // A jump of more than half a revolution means the count wrapped.
                    if (w_enc_delta > TURN_HALF) begin
                        r_turns <= r_turns - 32'sd1;
                    end else if (w_enc_delta < -TURN_HALF) begin
                        r_turns <= r_turns + 32'sd1;
                    end
                end
            end

            if (r_state == S_MUL_CFILT) begin
                r_speed <= w_spd_new;
            end
            if (r_state == S_MUL_TOTAL) begin
                r_current <= w_cur_new;
            end

            if ((r_state == S_DONE) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_in_acc) begin
            r_rpm   <= w_rpm;
            r_cdiff <= $signed({w_cur[15], w_cur}) - $signed({r_current[15], r_current});
        end
        if (r_state == S_MUL_ANGLE) begin
            // The product is the scaled speed sample; it always fits 32 bits.
            r_sdiff <= $signed({r_prod[31], r_prod[31:0]}) - $signed({r_speed[31], r_speed});
        end
        if (r_state == S_MUL_SFILT) begin
            r_angle <= (w_angle_raw[31:28] != 4'd0) ? ANGLE_MAX : w_angle_raw[27:0];
        end
        if (r_state == S_ADD_TOTAL) begin
            r_total <= {{4{r_prod[59]}}, r_prod} + {36'd0, r_angle};
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_m_data <= w_res_data;
            r_m_user <= r_res_acc;
        end
    end

    assign o_m_axis_tvalid   = r_m_valid;
    assign o_m_axis_tdata    = r_m_data;
    assign o_m_axis_tuser[0] = r_m_user;

    `MFFD_ASSERT_NEXT(a_reject_to_done, w_in_acc && !w_id_match,
        (r_state == S_DONE) && !r_res_acc, "rejected frame did not go straight to output")
    `MFFD_ASSERT_NEXT(a_frame_count, w_in_acc && w_id_match,
        r_frames == $past(r_frames) + 32'd1, "frame count did not advance by one")
    `MFFD_ASSERT_NEXT(a_turn_step, w_in_acc && w_id_match,
        (r_turns == $past(r_turns)) || (r_turns == $past(r_turns) + 32'sd1)
        || (r_turns == $past(r_turns) - 32'sd1), "turn count moved by more than one")
    `MFFD_ASSERT_SAME(a_reject_zero, r_m_valid && !r_m_user,
        r_m_data == '0, "rejected result carries nonzero data")

endmodule

/* bench/mffd_feedback_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the motor feedback frame decoder: watches the frame, result and
// configuration ports, predicts each result and compares it field by field.
// Depends on mffd_pkg for register indexes, reset values and constants.
module mffd_feedback_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    // Frame: encoder_count, speed_rpm, raw_current, temperature from bit 0 up.
    input  logic [mffd_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // Frame: frame_id.
    input  logic [mffd_pkg::IN_USER_W-1:0]    i_s_tuser,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // Result: single_turn_angle, filtered_speed, filtered_current, temperature_out,
    // turn_count, unwrapped angle, frame_count, zero fill from bit 0 up.
    input  logic [mffd_pkg::OUT_DATA_W-1:0]   i_m_tdata,
    // Result: accepted.
    input  logic [0:0]                        i_m_tuser,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_addr,
    input  logic [mffd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output int                                o_pending,
    output int                                o_errors,
    output int                                o_checked,
    output int                                o_accepted
);
    import mffd_pkg::*;

    localparam int     PRINT_CAP = 40;
    localparam longint SPEED_MAX = 64'sd2147483647;
    localparam longint SPEED_MIN = -64'sd2147483648;
    localparam longint AMP_MAX   = 64'sd32767;
    localparam longint AMP_MIN   = -64'sd32768;

    typedef struct packed {
        logic        accepted;
        logic [27:0] angle;
        logic [31:0] speed;
        logic [15:0] current;
        logic [7:0]  temp;
        logic [31:0] turns;
        logic [63:0] total;
        logic [31:0] frames;
    } t_feedback;

    // Register copy.
    logic [10:0] reg_frame_id;
    logic [16:0] reg_speed_w;
    logic [16:0] reg_current_w;
    logic [23:0] reg_deg_per_cnt;
    logic [15:0] reg_rpm_scale;

    // Decoder state copy.
    logic [15:0] last_enc;
    logic [31:0] speed_state;
    logic [15:0] current_state;
    logic [31:0] turn_state;
    logic [31:0] frame_state;
    logic [7:0]  temp_state;

    t_feedback expected_feedback[$];
    int        err_count = 0;

    initial begin
        o_pending  = 0;
        o_checked  = 0;
        o_accepted = 0;
    end

    assign o_errors = err_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("%0t: %s mismatch on result %0d: got 0x%0h, expected 0x%0h",
                     $realtime, what, o_checked, got, want);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Applies one frame to the state copy and returns the result it must produce.
    task automatic decode_feedback_frame(input logic [10:0] fid, input logic [15:0] enc,
                                         input logic signed [15:0] rpm,
                                         input logic signed [15:0] cur,
                                         input logic [7:0] temp, output t_feedback res);
        logic [39:0] prod;
        logic [27:0] angle;
        longint      w;
        longint      acc;
        longint      d;
        longint      total;
        res = '0;
        if (fid != reg_frame_id)
            return;
        frame_state = frame_state + 32'd1;

        prod = {24'd0, enc} * {16'd0, reg_deg_per_cnt};
        if (prod[39:8] > {4'd0, ANGLE_MAX})
            angle = ANGLE_MAX;
        else
            angle = prod[35:8];

        // Weights above one act as one.
        w = (reg_speed_w > ONE_Q16) ? longint'(ONE_Q16) : longint'(reg_speed_w);
        acc = (longint'(ONE_Q16) - w) * longint'($signed(speed_state))
            + w * (longint'(reg_rpm_scale) * longint'(rpm));
        acc = acc >>> 16;
        if (acc > SPEED_MAX) acc = SPEED_MAX;
        if (acc < SPEED_MIN) acc = SPEED_MIN;
        speed_state = acc[31:0];

        // The current filter truncates toward zero, unlike the speed filter.
        w = (reg_current_w > ONE_Q16) ? longint'(ONE_Q16) : longint'(reg_current_w);
        acc = ((longint'(ONE_Q16) - w) * longint'($signed(current_state))
            + w * longint'(cur)) / 64'sd65536;
        if (acc > AMP_MAX) acc = AMP_MAX;
        if (acc < AMP_MIN) acc = AMP_MIN;
        current_state = acc[15:0];

        temp_state = temp;

        d = longint'(enc) - longint'(last_enc);
        if (d > longint'(TURN_HALF))
            turn_state = turn_state - 32'd1;
        else if (d < -longint'(TURN_HALF))
            turn_state = turn_state + 32'd1;
        last_enc = enc;

        total = longint'($signed(turn_state)) * longint'(FULL_TURN_Q16) + longint'(angle);

        res.accepted = 1'b1;
        res.angle    = angle;
        res.speed    = speed_state;
        res.current  = current_state;
        res.temp     = temp_state;
        res.turns    = turn_state;
        res.total    = total;
        res.frames   = frame_state;
    endtask

    always @(posedge i_clk) begin : monitor
        t_feedback got;
        t_feedback want;
        if (!i_rst_n) begin
            reg_frame_id    = RST_EXPECTED_ID;
            reg_speed_w     = RST_SPEED_W;
            reg_current_w   = RST_CURRENT_W;
            reg_deg_per_cnt = RST_DEG_PER_CNT;
            reg_rpm_scale   = RST_RPM_SCALE;
            last_enc        = '0;
            speed_state     = '0;
            current_state   = '0;
            turn_state      = '0;
            frame_state     = '0;
            temp_state      = '0;
            expected_feedback.delete();
        end else begin
            // A result leaving now belongs to an earlier request, so pop before pushing.
            if (i_m_tvalid && i_m_tready) begin
                got.accepted = i_m_tuser[0];
                got.angle    = i_m_tdata[27:0];
                got.speed    = i_m_tdata[59:28];
                got.current  = i_m_tdata[75:60];
                got.temp     = i_m_tdata[83:76];
                got.turns    = i_m_tdata[115:84];
                got.total    = i_m_tdata[179:116];
                got.frames   = i_m_tdata[211:180];
                if (expected_feedback.size() == 0) begin
                    report_mismatch("unexpected result", 64'(got.angle), 64'd0);
                end else begin
                    want = expected_feedback.pop_front();
                    check_field("accepted", 64'(got.accepted), 64'(want.accepted));
                    check_field("single_turn_angle", 64'(got.angle), 64'(want.angle));
                    check_field("filtered_speed", 64'(got.speed), 64'(want.speed));
                    check_field("filtered_current", 64'(got.current), 64'(want.current));
                    check_field("temperature_out", 64'(got.temp), 64'(want.temp));
                    check_field("turn_count", 64'(got.turns), 64'(want.turns));
                    check_field("unwrapped_angle", got.total, want.total);
                    check_field("frame_count", 64'(got.frames), 64'(want.frames));
                    check_field("zero fill", 64'(i_m_tdata[215:212]), 64'd0);
                    if (want.accepted)
                        o_accepted++;
                end
                o_checked++;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_EXPECTED_ID: reg_frame_id    = i_cfg_wdata[10:0];
                    CFG_SPEED_W:     reg_speed_w     = i_cfg_wdata[16:0];
                    CFG_CURRENT_W:   reg_current_w   = i_cfg_wdata[16:0];
                    CFG_DEG_PER_CNT: reg_deg_per_cnt = i_cfg_wdata[23:0];
                    CFG_RPM_SCALE:   reg_rpm_scale   = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_feedback_frame(i_s_tuser[10:0], i_s_tdata[15:0], i_s_tdata[31:16],
                                      i_s_tdata[47:32], i_s_tdata[55:48], want);
                expected_feedback.push_back(want);
            end
        end
        o_pending = expected_feedback.size();
    end

endmodule

/* bench/tb_motor_feedback_frame_decoder_core.sv */
`timescale 1ns / 1ps
// Top of the motor feedback frame decoder bench: clock, reset, register settings,
// frame stimulus and result back-pressure. Checking is in mffd_feedback_checker.
// Depends on mffd_pkg and motor_feedback_frame_decoder_core.
module tb_motor_feedback_frame_decoder_core;
    import mffd_pkg::*;

    localparam int PHASES          = 8;
    localparam int FRAMES_PER_PHASE = 153;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int CFG_ADDR_TOP    = 7;

    logic                    i_clk     = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata   = '0;
    logic [IN_USER_W-1:0]    s_tuser   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [0:0]              m_tuser;
    logic                    cfg_we    = 1'b0;
    logic [2:0]              cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    int pending;
    int errors;
    int checked;
    int accepted_seen;

    // Traffic shaping, set by the stimulus process.
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;
    bit rx_hold_req = 1'b0;

    int          frames_sent = 0;
    int          settings    = 0;
    logic [15:0] prev_enc    = '0;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    motor_feedback_frame_decoder_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    mffd_feedback_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_checked   (checked),
        .o_accepted  (accepted_seen)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(1, 3);
        else if (r < 18)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [16:0] pick_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 17'd0;
        else if (r == 1)
            return ONE_Q16;
        else if (r == 2)
            return 17'($urandom_range(65537, 131071));
        return 17'($urandom_range(1, 65535));
    endfunction

    // Encoder walk: mostly small steps, some near the half-turn threshold, some wild.
    function automatic logic [15:0] next_encoder(input logic [15:0] last);
        int r;
        int step;
        r = $urandom_range(0, 9);
        if (r < 6)
            step = $urandom_range(0, 600);
        else if (r < 8)
            step = $urandom_range(4090, 4102);
        else if (r < 9)
            step = $urandom_range(4097, 32767);
        else
            return 16'($urandom);
        if ($urandom_range(0, 1))
            step = -step;
        return last + 16'(step);
    endfunction

    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 16'h7FFF;
        else if (r == 1)
            return 16'h8000;
        return 16'($urandom);
    endfunction

    // Receiver: random stalls, steady stretches, and one long hold-off on request.
    initial begin : receiver
        int n;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_steady || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                n = idle_len();
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    // Offers one frame, waits for the request to be taken, then idles at random.
    task automatic send_frame(input logic [10:0] fid, input logic [15:0] enc,
                              input logic [15:0] rpm, input logic [15:0] cur,
                              input logic [7:0] temp);
        int gap;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {temp, cur, rpm, enc};
        s_tuser  <= fid;
        do @(posedge i_clk); while (!s_tready);
        frames_sent++;
        prev_enc = enc;
        gap = (tx_steady || $urandom_range(0, 9) < 6) ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
    endtask

    task automatic apply_settings(input logic [10:0] fid, input logic [16:0] speed_w,
                                  input logic [16:0] current_w, input logic [23:0] dpc,
                                  input logic [15:0] scale, input bit junk);
        int a;
        write_reg(CFG_EXPECTED_ID, CFG_DATA_W'(fid));
        write_reg(CFG_SPEED_W, CFG_DATA_W'(speed_w));
        write_reg(CFG_CURRENT_W, CFG_DATA_W'(current_w));
        write_reg(CFG_DEG_PER_CNT, dpc);
        write_reg(CFG_RPM_SCALE, CFG_DATA_W'(scale));
        // Writes to unmapped indexes must leave every register alone.
        if (junk)
            for (a = int'(CFG_RPM_SCALE) + 1; a <= CFG_ADDR_TOP; a++)
                write_reg(3'(a), CFG_DATA_W'($urandom));
        @(negedge i_clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial begin : stimulus
        int          p;
        int          k;
        int          cnt;
        logic [10:0] ph_id;
        logic [10:0] fid;
        logic [16:0] ph_sw;
        logic [16:0] ph_cw;
        logic [23:0] ph_dpc;
        logic [15:0] ph_scale;

        repeat (8) @(negedge i_clk);
        rst_n <= 1'b1;

        // Reset settings: threshold crossings, extremes and rejected identifiers.
        send_frame(RST_EXPECTED_ID, 16'h0000, 16'h0000, 16'h0000, 8'h00);
        send_frame(RST_EXPECTED_ID, 16'hFFFF, 16'h7FFF, 16'h7FFF, 8'hFF);
        send_frame(RST_EXPECTED_ID, 16'h0000, 16'h8000, 16'h8000, 8'h00);
        send_frame(RST_EXPECTED_ID, 16'd4096, 16'd100, -16'sd100, 8'd17);
        send_frame(RST_EXPECTED_ID, 16'd0, 16'hFFFF, 16'h0001, 8'd33);
        send_frame(RST_EXPECTED_ID, 16'd4097, 16'h0001, 16'hFFFF, 8'd66);
        send_frame(RST_EXPECTED_ID, 16'd0, 16'h1234, 16'hEDCB, 8'd99);
        send_frame(RST_EXPECTED_ID ^ 11'd1, 16'd1234, 16'h7FFF, 16'h7FFF, 8'hAA);
        send_frame(11'd0, 16'd9999, 16'h8000, 16'h8000, 8'h55);
        send_frame(11'h7FF, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF);
        send_frame(RST_EXPECTED_ID ^ 11'h400, 16'd30000, 16'h0042, 16'h0042, 8'h01);
        send_frame(RST_EXPECTED_ID, 16'h8000, 16'hFFFF, 16'h0001, 8'h80);
        send_frame(RST_EXPECTED_ID, 16'd60000, 16'h7FFF, 16'h8000, 8'h7F);
        send_frame(RST_EXPECTED_ID, 16'd10, 16'h8000, 16'h7FFF, 8'hFE);
        send_frame(RST_EXPECTED_ID, 16'd60000, 16'h0000, 16'h0000, 8'h0F);
        send_frame(RST_EXPECTED_ID, 16'd55000, 16'h4000, 16'hC000, 8'hF0);
        send_frame(RST_EXPECTED_ID, 16'd50903, 16'h0000, 16'h0000, 8'h3C);
        send_frame(RST_EXPECTED_ID, 16'd46806, 16'h0000, 16'h0000, 8'hC3);
        wait_idle();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    ph_id = 11'd0; ph_sw = 17'd0; ph_cw = 17'd0;
                    ph_dpc = 24'hFFFFFF; ph_scale = 16'hFFFF;
                end
                1: begin
                    ph_id = 11'h7FF; ph_sw = ONE_Q16; ph_cw = ONE_Q16;
                    ph_dpc = 24'd0; ph_scale = 16'd0;
                end
                2: begin
                    ph_id = 11'($urandom); ph_sw = 17'h1FFFF;
                    ph_cw = 17'($urandom_range(65537, 131071));
                    ph_dpc = RST_DEG_PER_CNT; ph_scale = RST_RPM_SCALE;
                end
                default: begin
                    ph_id = 11'($urandom); ph_sw = pick_weight(); ph_cw = pick_weight();
                    ph_dpc = $urandom_range(0, 1) ? 24'($urandom_range(0, 24'hFFFFF))
                                                  : 24'($urandom);
                    ph_scale = 16'($urandom);
                end
            endcase
            apply_settings(ph_id, ph_sw, ph_cw, ph_dpc, ph_scale, p == 2 || p == 6);
            tx_steady = (p == 5);
            rx_steady = (p == 5 || p == 6);

            send_frame(ph_id, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF);
            send_frame(ph_id, 16'h0000, 16'h8000, 16'h7FFF, 8'h00);
            for (k = 0; k < FRAMES_PER_PHASE; k++) begin
                // Long receiver hold-off while frames keep coming, so input stalls.
                if (p == 3 && k == FRAMES_PER_PHASE / 2)
                    rx_hold_req = 1'b1;
                if (p == 4 && k == FRAMES_PER_PHASE / 2)
                    wait_idle();
                cnt = $urandom_range(0, 99);
                if (cnt < 85)
                    fid = ph_id;
                else if (cnt < 93)
                    fid = ph_id ^ (11'd1 << $urandom_range(0, 10));
                else
                    fid = 11'($urandom);
                send_frame(fid, next_encoder(prev_enc), pick_sample(), pick_sample(),
                           8'($urandom));
            end
            wait_idle();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        cnt = 0;
        while (pending != 0 && cnt < DRAIN_LIMIT) begin
            @(negedge i_clk);
            cnt++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Sent %0d frames over %0d register settings; %0d results checked, %0d accepted.",
                 frames_sent, settings + 1, checked, accepted_seen);
        $display("Covered turn unwrap both ways, angle saturation, weights of zero, one and above.");
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d results never arrived", errors, pending);
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Timed out with %0d results outstanding", pending);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* motor_feedback_frame_decoder_core.f */
+incdir+src
src/mffd_pkg.sv
src/motor_feedback_frame_decoder_core.sv
bench/mffd_feedback_checker.sv
bench/tb_motor_feedback_frame_decoder_core.sv
